// ===== rtl/core/tep_pkg.sv =====
// ----------------------------------------------------------------------------
// tep_pkg: shared definitions for the terminal escape parser
// Command codes, character codes, parameter and queue sizes, and the
// record that the parser front end hands to the command back end.
// ----------------------------------------------------------------------------
package tep_pkg;

	localparam int MAX_PARAMS = 4;
	localparam int PIDX_W     = $clog2(MAX_PARAMS);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [15:0] PARAM_SAT = 16'hFFFF;

	// Character codes the parser reacts to.
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_EIGHT  = 8'h38;
	localparam logic [7:0] CH_LC_C   = 8'h63;
	localparam logic [7:0] CH_LC_H   = 8'h68;
	localparam logic [7:0] CH_LC_L   = 8'h6C;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_B   = 8'h42;
	localparam logic [7:0] CH_UC_C   = 8'h43;
	localparam logic [7:0] CH_UC_D   = 8'h44;
	localparam logic [7:0] CH_UC_E   = 8'h45;
	localparam logic [7:0] CH_UC_H   = 8'h48;
	localparam logic [7:0] CH_UC_J   = 8'h4A;
	localparam logic [7:0] CH_UC_K   = 8'h4B;

	localparam logic [15:0] MODE_CURSOR_A = 16'd25;
	localparam logic [15:0] MODE_CURSOR_B = 16'd50;

	typedef enum logic [4:0] {
		CMD_PRINT       = 5'd0,
		CMD_LF          = 5'd1,
		CMD_CR          = 5'd2,
		CMD_BS          = 5'd3,
		CMD_TAB         = 5'd4,
		CMD_RESET       = 5'd5,
		CMD_NEXT_LINE   = 5'd6,
		CMD_SAVE        = 5'd7,
		CMD_RESTORE     = 5'd8,
		CMD_CURSOR_ON   = 5'd9,
		CMD_CURSOR_OFF  = 5'd10,
		CMD_UP          = 5'd11,
		CMD_DOWN        = 5'd12,
		CMD_RIGHT       = 5'd13,
		CMD_LEFT        = 5'd14,
		CMD_GOTO        = 5'd15,
		CMD_ES_BELOW    = 5'd16,
		CMD_ES_ABOVE    = 5'd17,
		CMD_ES_ALL      = 5'd18,
		CMD_EL_RIGHT    = 5'd19,
		CMD_EL_LEFT     = 5'd20,
		CMD_EL_ALL      = 5'd21
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_ESCAPE   = 5'b00010,
		ST_BRACKET  = 5'b00100,
		ST_QUESTION = 5'b01000,
		ST_SKIP     = 5'b10000
	} pstate_t;

	// One decoded action: the command and its raw operands.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] a0;
		logic [15:0] a1;
	} rec_t;

endpackage

// ===== rtl/core/tep_if.sv =====
// ----------------------------------------------------------------------------
// tep_if: valid/ready channels of the terminal escape parser
// One interface for received bytes and one for display commands.
// ----------------------------------------------------------------------------
interface tep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tep_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  command;
	logic [15:0] arg_first;
	logic [15:0] arg_second;

	modport source (output valid, output command, output arg_first, output arg_second,
		input ready);
	modport sink   (input valid, input command, input arg_first, input arg_second,
		output ready);
endinterface

// ===== rtl/core/tep_front.sv =====
// ----------------------------------------------------------------------------
// tep_front: escape sequence parser front end
// Accepts one byte per beat, tracks the parse state and the decimal
// parameters, and pushes one record for every recognized action.
// ----------------------------------------------------------------------------
module tep_front (
	input  logic          clk,
	input  logic          arst_n,
	tep_byte_if.sink      rx,
	output logic          push,
	output tep_pkg::rec_t push_rec,
	input  logic          push_ready
);
	import tep_pkg::*;

	pstate_t           state_q, state_d;
	logic [15:0]       params_q [MAX_PARAMS];
	logic [15:0]       params_d [MAX_PARAMS];
	logic [PIDX_W-1:0] idx_q, idx_d;
	logic              fire;
	logic              emit;
	logic [7:0]        c;
	logic [15:0]       p0, p1, pcur;
	logic [19:0]       acc;

	// Space is reserved up front, so a beat is taken only when a push could land.
	assign rx.ready = push_ready;
	assign fire     = rx.valid && rx.ready;
	assign push     = fire && emit;
	assign c        = rx.rx_byte;
	assign p0       = params_q[0];
	assign p1       = params_q[1];
	assign pcur     = params_q[idx_q];
	// Times ten as shift and add, plus the new digit.
	assign acc      = {1'b0, pcur, 3'b000} + {3'b000, pcur, 1'b0} + {16'h0000, c[3:0]};

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		params_d = params_q;
		emit     = 1'b0;
		push_rec = '{cmd: CMD_PRINT, a0: 16'h0000, a1: 16'h0000};
		case (state_q)
			ST_IDLE: begin
				case (c)
					CH_ESC: state_d = ST_ESCAPE;
					CH_LF: begin emit = 1'b1; push_rec.cmd = CMD_LF; end
					CH_CR: begin emit = 1'b1; push_rec.cmd = CMD_CR; end
					CH_BS: begin emit = 1'b1; push_rec.cmd = CMD_BS; end
					CH_HT: begin emit = 1'b1; push_rec.cmd = CMD_TAB; end
					default: begin
						if (c inside {[CH_SPACE:CH_DEL]}) begin
							emit        = 1'b1;
							push_rec.a0 = {8'h00, c};
						end
					end
				endcase
			end
			ST_ESCAPE: begin
				state_d = ST_IDLE;
				case (c)
					CH_LC_C: begin
						idx_d        = '0;
						emit         = 1'b1;
						push_rec.cmd = CMD_RESET;
					end
					CH_UC_E:  begin emit = 1'b1; push_rec.cmd = CMD_NEXT_LINE; end
					CH_SEVEN: begin emit = 1'b1; push_rec.cmd = CMD_SAVE; end
					CH_EIGHT: begin emit = 1'b1; push_rec.cmd = CMD_RESTORE; end
					CH_LBRACK: begin
						state_d = ST_BRACKET;
						idx_d   = '0;
						for (int i = 0; i < MAX_PARAMS; i++) params_d[i] = 16'h0000;
					end
					CH_LPAREN, CH_RPAREN, CH_HASH: state_d = ST_SKIP;
					default: ;
				endcase
			end
			ST_BRACKET, ST_QUESTION: begin
				if (c inside {[CH_ZERO:CH_NINE]}) begin
					params_d[idx_q] = (acc > 20'(PARAM_SAT)) ? PARAM_SAT : acc[15:0];
				end else if (c == CH_SEMI) begin
					// The index sticks at the last slot.
					if (idx_q < PIDX_W'(MAX_PARAMS - 1)) idx_d = PIDX_W'(idx_q + 1'b1);
				end else if (c == CH_QUEST) begin
					state_d = ST_QUESTION;
				end else begin
					state_d     = ST_IDLE;
					push_rec.a0 = p0;
					push_rec.a1 = p1;
					case (c)
						CH_LC_H, CH_LC_L: begin
							if (p0 == MODE_CURSOR_A || p0 == MODE_CURSOR_B) begin
								emit         = 1'b1;
								push_rec.cmd = (c == CH_LC_H) ? CMD_CURSOR_ON : CMD_CURSOR_OFF;
							end
						end
						CH_UC_A: begin emit = 1'b1; push_rec.cmd = CMD_UP; end
						CH_UC_B: begin emit = 1'b1; push_rec.cmd = CMD_DOWN; end
						CH_UC_C: begin emit = 1'b1; push_rec.cmd = CMD_RIGHT; end
						CH_UC_D: begin emit = 1'b1; push_rec.cmd = CMD_LEFT; end
						CH_UC_H, CH_LC_F: begin emit = 1'b1; push_rec.cmd = CMD_GOTO; end
						CH_UC_J: begin
							emit = (p0[15:2] == 14'd0) && (p0[1:0] != 2'd3);
							case (p0[1:0])
								2'd0:    push_rec.cmd = CMD_ES_BELOW;
								2'd1:    push_rec.cmd = CMD_ES_ABOVE;
								default: push_rec.cmd = CMD_ES_ALL;
							endcase
						end
						CH_UC_K: begin
							emit = (p0[15:2] == 14'd0) && (p0[1:0] != 2'd3);
							case (p0[1:0])
								2'd0:    push_rec.cmd = CMD_EL_RIGHT;
								2'd1:    push_rec.cmd = CMD_EL_LEFT;
								default: push_rec.cmd = CMD_EL_ALL;
							endcase
						end
						default: ;
					endcase
				end
			end
			ST_SKIP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			for (int i = 0; i < MAX_PARAMS; i++) params_q[i] <= 16'h0000;
		end else if (fire) begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			params_q <= params_d;
		end
	end

endmodule

// ===== rtl/core/tep_queue.sv =====
// ----------------------------------------------------------------------------
// tep_queue: action queue between parser and command stage
// A small FIFO of decoded records so that either side can stall alone.
// ----------------------------------------------------------------------------
module tep_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tep_pkg::rec_t push_rec,
	output logic          push_ready,
	input  logic          pop,
	output tep_pkg::rec_t pop_rec,
	output logic          pop_valid
);
	import tep_pkg::*;

	rec_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_rec    = entry_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wptr_q + 1'b1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rptr_q + 1'b1);
			end
			if (do_push && !do_pop) count_q <= QCNT_W'(count_q + 1'b1);
			else if (do_pop && !do_push) count_q <= QCNT_W'(count_q - 1'b1);
		end
	end

endmodule

// ===== rtl/core/tep_back.sv =====
// ----------------------------------------------------------------------------
// tep_back: display command stage
// Pops decoded records, forms the final arguments (default counts and
// zero-based goto coordinates) and holds the result in an output register.
// ----------------------------------------------------------------------------
module tep_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  tep_pkg::rec_t pop_rec,
	output logic          pop,
	tep_cmd_if.source     tx
);
	import tep_pkg::*;

	logic        valid_q;
	logic [4:0]  command_q;
	logic [15:0] arg_first_q, arg_second_q;
	logic [15:0] arg_first_d, arg_second_d;
	logic [15:0] a0_one, a1_one;

	// A zero parameter counts as one.
	assign a0_one = (pop_rec.a0 == 16'h0000) ? 16'h0001 : pop_rec.a0;
	assign a1_one = (pop_rec.a1 == 16'h0000) ? 16'h0001 : pop_rec.a1;
	assign pop    = pop_valid && (!valid_q || tx.ready);

	always_comb begin
		arg_first_d  = 16'h0000;
		arg_second_d = 16'h0000;
		case (pop_rec.cmd)
			CMD_PRINT: arg_first_d = pop_rec.a0;
			CMD_UP, CMD_DOWN, CMD_RIGHT, CMD_LEFT: arg_first_d = a0_one;
			CMD_GOTO: begin
				arg_first_d  = a0_one - 16'h0001;
				arg_second_d = a1_one - 16'h0001;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || tx.ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			command_q    <= pop_rec.cmd;
			arg_first_q  <= arg_first_d;
			arg_second_q <= arg_second_d;
		end
	end

	assign tx.valid      = valid_q;
	assign tx.command    = command_q;
	assign tx.arg_first  = arg_first_q;
	assign tx.arg_second = arg_second_q;

endmodule

// ===== rtl/core/terminal_escape_parser_core.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_parser_core: VT100-subset escape sequence parser
// Turns a received byte stream into display commands with arguments.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle on rx while the action queue has room;
// every byte that completes a recognized action yields one beat on tx
// (command, arg_first, arg_second), and bytes with no effect yield none. A
// result passes through two registers: an entry of the two-entry action queue,
// written by the parser front end, and the command stage output register.
// When tx stalls, the queue absorbs up to two actions before rx ready drops.
// ----------------------------------------------------------------------------
module terminal_escape_parser_core (
	input  logic      clk,
	input  logic      arst_n,
	tep_byte_if.sink  rx,
	tep_cmd_if.source tx
);
	import tep_pkg::*;

	logic push, push_ready, pop, pop_valid;
	rec_t push_rec, pop_rec;

	tep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push       (push),
		.push_rec   (push_rec),
		.push_ready (push_ready)
	);

	tep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_rec    (pop_rec),
		.pop_valid  (pop_valid)
	);

	tep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_rec   (pop_rec),
		.pop       (pop),
		.tx        (tx)
	);

endmodule
